>>> rtl/prqs_pkg.sv
// Shared types, codes and helpers for the priority ready-queue scheduler.
package prqs_pkg;

  localparam int LVL_W    = 5;
  localparam int TID_W    = 6;
  localparam int MASK_W   = 32;
  localparam int BEST_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CMD_W    = 3;
  localparam logic [MASK_W-1:0] TOP_BIT = 32'h8000_0000;
  localparam logic [7:0] LOCK_MAX = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_READY    = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_RESCHED  = 3'd2,
    CMD_YIELD    = 3'd3,
    CMD_LOCK     = 3'd4,
    CMD_UNLOCK   = 3'd5,
    CMD_SET_PRIO = 3'd6,
    CMD_BLOCK    = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_SWITCHED = 2'd1,
    ST_IDLE     = 2'd2,
    ST_LOCKED   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_SEL, S_SEL2, S_TK_A, S_TK_B, S_TK_C,
    S_PUT_A, S_PUT_B, S_FIN
  } state_t;

  // where a list operation continues when it is through
  typedef enum logic [2:0] {
    R_DONE, R_PUT, R_SEL, R_SELQ, R_DISP
  } ret_t;

  // count of leading zeros, 32 for an empty mask
  function automatic logic [BEST_W-1:0] lead_zeros(input logic [MASK_W-1:0] v);
    logic [BEST_W-1:0] n;
    logic              found;
    n     = BEST_W'(MASK_W);
    found = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (!found && v[MASK_W-1-i]) begin
        n     = BEST_W'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/priority_ready_queue_scheduler.sv
// Priority ready-queue scheduler: per-level FIFO lists kept in a thread link memory.
//
//  channel | dir | beat contents
//  s_axis  | in  | tuser: cmd; tdata: thread_id, priority_req
//  m_axis  | out | tuser: status; tdata: running_thread .. ready_levels
//
// Lock and unlock go from S_IDLE straight to S_FIN; a set priority that requeues and
// then dispatches passes S_DEC and the take, put and select states. A beat is taken
// only in S_IDLE. The single-port thread memory allows one list update per cycle.
// After reset a clearing pass over every thread entry runs with s_axis_tready low.
// A result waits in the output register while the next beat is taken; the
// following result holds in S_FIN until the register has been emptied.
module priority_ready_queue_scheduler
  import prqs_pkg::*;
#(
  parameter int NUM_THREADS = 64,
  parameter int NUM_LEVELS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
  input  logic [15:0] s_axis_tdata,   // thread_id[5:0], priority_req[10:6], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic [47:0] m_axis_tdata    // running_thread[5:0], running_valid[6],
                                      // best_priority[12:7], ready_levels[44:13], zero fill
);

  localparam int AW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int PW = $clog2(NUM_THREADS + 1);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam logic [PW-1:0] NONE = PW'(NUM_THREADS);

  // thread memory, one shared port with per-field write enables
  logic            mem_rdy [NUM_THREADS];
  logic [LVL_W-1:0] mem_lvl [NUM_THREADS];
  logic [PW-1:0]   mem_nxt [NUM_THREADS];
  logic [PW-1:0]   mem_prv [NUM_THREADS];
  logic            rd_rdy;
  logic [LVL_W-1:0] rd_lvl;
  logic [PW-1:0]   rd_nxt, rd_prv;
  logic [AW-1:0]   ma;
  logic            mre, we_rdy, we_lvl, we_nxt, we_prv;
  logic            wd_rdy;
  logic [LVL_W-1:0] wd_lvl;
  logic [PW-1:0]   wd_nxt, wd_prv;

  logic [PW-1:0] head [NUM_LEVELS];
  logic [PW-1:0] tail [NUM_LEVELS];
  logic          hd_we, tl_we;
  logic [LW-1:0] hd_idx, tl_idx;
  logic [PW-1:0] hd_val, tl_val;

  state_t state, state_next;
  cmd_t   cmd_r, cmd_r_next;
  logic [TID_W-1:0] tid_r, tid_r_next;
  logic [LVL_W-1:0] prio_r, prio_r_next;
  logic   yld, yld_next;
  logic [AW-1:0] wt, wt_next;
  logic [LVL_W-1:0] wl, wl_next;
  ret_t   ret, ret_next;
  status_t st, st_next;
  logic [PW-1:0] put_ptr, put_ptr_next;
  logic [AW-1:0] cur_tid, cur_tid_next;
  logic   cur_valid, cur_valid_next;
  logic   cur_run, cur_run_next;
  logic [LVL_W-1:0] cur_lvl, cur_lvl_next;
  logic   hint, hint_next;
  logic [7:0] lock_cnt, lock_cnt_next;
  logic [MASK_W-1:0] mask, mask_next;
  logic [AW-1:0] clr, clr_next;
  logic   load_out;

  logic   accept;
  cmd_t   in_cmd;
  logic [TID_W-1:0] in_tid;
  logic [LVL_W-1:0] in_prio;
  logic   in_tid_ok, tid_ok_r, run_cur;
  logic [BEST_W-1:0] best;
  logic [LVL_W-1:0]  best_lvl;
  logic [PW-1:0] tl_cur;
  logic   fire_ret;

  assign s_axis_tready = (state == S_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_cmd  = cmd_t'(s_axis_tuser);
  assign in_tid  = s_axis_tdata[5:0];
  assign in_prio = (32'(s_axis_tdata[10:6]) >= 32'(NUM_LEVELS)) ?
                   LVL_W'(NUM_LEVELS - 1) : s_axis_tdata[10:6];
  assign in_tid_ok = 32'(in_tid) < 32'(NUM_THREADS);
  assign tid_ok_r  = 32'(tid_r) < 32'(NUM_THREADS);
  assign run_cur   = cur_valid && cur_run && (cur_tid == AW'(tid_r));
  assign best      = lead_zeros(mask);
  assign best_lvl  = best[LVL_W-1:0];
  assign tl_cur    = tail[wl[LW-1:0]];

  always_comb begin
    state_next    = state;
    cmd_r_next    = cmd_r;
    tid_r_next    = tid_r;
    prio_r_next   = prio_r;
    yld_next      = yld;
    wt_next       = wt;
    wl_next       = wl;
    ret_next      = ret;
    st_next       = st;
    put_ptr_next  = put_ptr;
    cur_tid_next  = cur_tid;
    cur_valid_next = cur_valid;
    cur_run_next  = cur_run;
    cur_lvl_next  = cur_lvl;
    hint_next     = hint;
    lock_cnt_next = lock_cnt;
    mask_next     = mask;
    clr_next      = clr;
    load_out      = 1'b0;
    fire_ret      = 1'b0;
    ma = wt; mre = 1'b0;
    we_rdy = 1'b0; we_lvl = 1'b0; we_nxt = 1'b0; we_prv = 1'b0;
    wd_rdy = 1'b0; wd_lvl = '0; wd_nxt = NONE; wd_prv = NONE;
    hd_we = 1'b0; tl_we = 1'b0;
    hd_idx = wl[LW-1:0]; tl_idx = wl[LW-1:0];
    hd_val = NONE; tl_val = NONE;

    unique case (state)
      S_CLEAR: begin
        ma = clr; we_rdy = 1'b1; we_lvl = 1'b1;
        clr_next = clr + AW'(1);
        if (clr == AW'(NUM_THREADS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_r_next  = in_cmd;
          tid_r_next  = in_tid;
          prio_r_next = in_prio;
          st_next     = ST_DONE;
          yld_next    = 1'b0;
          ma          = AW'(in_tid);
          state_next  = S_FIN;
          case (in_cmd)
            CMD_READY, CMD_REMOVE, CMD_SET_PRIO: begin
              if (in_tid_ok) begin
                mre = 1'b1;
                state_next = S_DEC;
              end
            end
            CMD_RESCHED: if (hint) state_next = S_SEL;
            CMD_YIELD: begin
              yld_next = 1'b1;
              state_next = S_SEL;
            end
            CMD_LOCK:   if (lock_cnt != LOCK_MAX) lock_cnt_next = lock_cnt + 8'd1;
            CMD_UNLOCK: if (lock_cnt != 8'd0) lock_cnt_next = lock_cnt - 8'd1;
            default: begin
              if (cur_valid && cur_run) begin
                cur_run_next = 1'b0;
                hint_next = 1'b1;
                state_next = S_SEL;
              end else if (hint) begin
                state_next = S_SEL;
              end
            end
          endcase
        end
      end
      S_DEC: begin
        wt_next = AW'(tid_r);
        ma = AW'(tid_r);
        state_next = S_FIN;
        case (cmd_r)
          CMD_READY: begin
            if (tid_ok_r && !rd_rdy && !run_cur) begin
              wl_next = prio_r; ret_next = R_DONE; state_next = S_PUT_A;
            end
          end
          CMD_REMOVE: begin
            if (rd_rdy) begin
              wl_next = rd_lvl; ret_next = R_DONE; state_next = S_TK_A;
            end
          end
          default: begin
            if (rd_lvl != prio_r) begin
              if (rd_rdy) begin
                wl_next = rd_lvl; ret_next = R_PUT; state_next = S_TK_A;
              end else begin
                we_lvl = 1'b1; wd_lvl = prio_r;
                if (cur_tid == AW'(tid_r)) cur_lvl_next = prio_r;
                if (run_cur) hint_next = 1'b1;
                if (run_cur || hint) state_next = S_SEL;
              end
            end
          end
        endcase
      end
      S_SEL: begin
        state_next = S_SEL2;
        if (lock_cnt != 8'd0) begin
          st_next = ST_LOCKED; state_next = S_FIN;
        end else if (cur_valid && cur_run) begin
          if (!yld && ({1'b0, cur_lvl} <= best)) begin
            st_next = ST_DONE; state_next = S_FIN;
          end else begin
            cur_run_next = 1'b0;
            wt_next = cur_tid; wl_next = cur_lvl;
            ret_next = R_SELQ; state_next = S_PUT_A;
          end
        end
      end
      S_SEL2: begin
        hint_next = 1'b0;
        state_next = S_FIN;
        if (mask == '0 || head[best_lvl[LW-1:0]] == NONE) begin
          mask_next = mask & ~(TOP_BIT >> best_lvl);
          cur_valid_next = 1'b0; cur_run_next = 1'b0; cur_tid_next = '0;
          st_next = ST_IDLE;
        end else begin
          ma = AW'(head[best_lvl[LW-1:0]]);
          mre = 1'b1;
          wt_next = AW'(head[best_lvl[LW-1:0]]);
          wl_next = best_lvl;
          ret_next = R_DISP;
          state_next = S_TK_A;
        end
      end
      S_TK_A: begin
        we_rdy = 1'b1; wd_rdy = 1'b0;
        if (rd_prv == NONE) begin
          hd_we = 1'b1; hd_val = rd_nxt;
        end
        if (rd_nxt == NONE) begin
          tl_we = 1'b1; tl_val = rd_prv;
        end
        if (rd_prv == NONE && rd_nxt == NONE) mask_next = mask & ~(TOP_BIT >> wl);
        state_next = S_TK_B;
      end
      S_TK_B: begin
        ma = AW'(rd_prv);
        we_nxt = (rd_prv != NONE); wd_nxt = rd_nxt;
        state_next = S_TK_C;
      end
      S_TK_C: begin
        ma = AW'(rd_nxt);
        we_prv = (rd_nxt != NONE); wd_prv = rd_prv;
        fire_ret = 1'b1;
      end
      S_PUT_A: begin
        we_rdy = 1'b1; we_lvl = 1'b1; we_nxt = 1'b1; we_prv = 1'b1;
        wd_rdy = 1'b1; wd_lvl = wl; wd_nxt = NONE; wd_prv = tl_cur;
        if (tl_cur == NONE) begin
          hd_we = 1'b1; hd_val = PW'(wt);
        end
        tl_we = 1'b1; tl_val = PW'(wt);
        mask_next = mask | (TOP_BIT >> wl);
        hint_next = 1'b1;
        if (wt == cur_tid) cur_lvl_next = wl;
        put_ptr_next = tl_cur;
        if (tl_cur != NONE) state_next = S_PUT_B;
        else fire_ret = 1'b1;
      end
      S_PUT_B: begin
        ma = AW'(put_ptr);
        we_nxt = 1'b1; wd_nxt = PW'(wt);
        fire_ret = 1'b1;
      end
      S_FIN: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (fire_ret) begin
      unique case (ret)
        R_DONE: state_next = S_FIN;
        R_PUT: begin
          wl_next = prio_r; ret_next = R_SEL; state_next = S_PUT_A;
        end
        R_SEL:  state_next = S_SEL;
        R_SELQ: state_next = S_SEL2;
        default: begin
          cur_tid_next = wt; cur_valid_next = 1'b1; cur_run_next = 1'b1;
          cur_lvl_next = wl; st_next = ST_SWITCHED; state_next = S_FIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mre) begin
      rd_rdy <= mem_rdy[ma];
      rd_lvl <= mem_lvl[ma];
      rd_nxt <= mem_nxt[ma];
      rd_prv <= mem_prv[ma];
    end
    if (we_rdy) mem_rdy[ma] <= wd_rdy;
    if (we_lvl) mem_lvl[ma] <= wd_lvl;
    if (we_nxt) mem_nxt[ma] <= wd_nxt;
    if (we_prv) mem_prv[ma] <= wd_prv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= NONE;
        tail[i] <= NONE;
      end
    end else begin
      if (hd_we) head[hd_idx] <= hd_val;
      if (tl_we) tail[tl_idx] <= tl_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cur_tid   <= '0;
      cur_valid <= 1'b0;
      cur_run   <= 1'b0;
      cur_lvl   <= '0;
      hint      <= 1'b0;
      lock_cnt  <= '0;
      mask      <= '0;
      m_axis_tvalid <= 1'b0;
      ret       <= R_DONE;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      cur_tid   <= cur_tid_next;
      cur_valid <= cur_valid_next;
      cur_run   <= cur_run_next;
      cur_lvl   <= cur_lvl_next;
      hint      <= hint_next;
      lock_cnt  <= lock_cnt_next;
      mask      <= mask_next;
      ret       <= ret_next;
      if (load_out) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_r_next;
    tid_r   <= tid_r_next;
    prio_r  <= prio_r_next;
    yld     <= yld_next;
    wt      <= wt_next;
    wl      <= wl_next;
    st      <= st_next;
    put_ptr <= put_ptr_next;
    if (load_out) begin
      m_axis_tuser <= st;
      m_axis_tdata <= {3'b000, mask, best, cur_valid, TID_W'(cur_tid)};
    end
  end

  a_run_needs_cur: assert property (@(posedge clk) disable iff (rst)
    cur_run |-> cur_valid) else $error("running without a current thread");

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_axis_tready) else $error("beat taken during clear");

  a_lock_sat: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == CMD_LOCK && lock_cnt == LOCK_MAX) |=> lock_cnt == LOCK_MAX)
    else $error("lock count wrapped");

  a_empty_best: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (m_axis_tdata[44:13] == '0) == (m_axis_tdata[12:7] == 6'd32))
    else $error("best level disagrees with ready bitmap");

endmodule

>>> bench/priority_ready_queue_scheduler_checker.sv
// Checker for the scheduler: watches both channels, predicts each result and compares.
module priority_ready_queue_scheduler_checker
  import prqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [1:0]  m_axis_tuser,
  input  logic [47:0] m_axis_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = 64;
  localparam int NL = 32;
  localparam logic [6:0] NIL = 7'd64;

  typedef struct packed {
    status_t     status;
    logic [5:0]  thread;
    logic        valid;
    logic [5:0]  best;
    logic [31:0] levels;
  } sched_result_t;

  sched_result_t expected_q[$];

  logic [31:0] rdy_mask;
  logic [6:0]  head[NL];
  logic [6:0]  tail[NL];
  logic [6:0]  nxt[NT];
  logic [6:0]  prv[NT];
  logic [4:0]  lvl[NT];
  logic        queued[NT];
  logic [5:0]  cur;
  logic        cur_v, cur_run, hint;
  int          locks;

  function automatic logic [5:0] clz(logic [31:0] v);
    for (int i = 0; i < 32; i++) if (v[31-i]) return 6'(i);
    return 6'd32;
  endfunction

  function automatic void sched_reset();
    rdy_mask = '0;
    for (int i = 0; i < NL; i++) begin
      head[i] = NIL;
      tail[i] = NIL;
    end
    for (int i = 0; i < NT; i++) begin
      nxt[i] = NIL;
      prv[i] = NIL;
      lvl[i] = '0;
      queued[i] = 1'b0;
    end
    cur = '0;
    cur_v = 0;
    cur_run = 0;
    locks = 0;
    hint = 0;
  endfunction

  function automatic void enqueue(int t);
    int l;
    l = lvl[t];
    prv[t] = tail[l];
    nxt[t] = NIL;
    if (tail[l] == NIL) head[l] = 7'(t);
    else nxt[tail[l][5:0]] = 7'(t);
    tail[l] = 7'(t);
    rdy_mask |= 32'h8000_0000 >> l;
    queued[t] = 1;
    hint = 1;
  endfunction

  function automatic void dequeue(int t);
    int l;
    logic [6:0] p, n;
    l = lvl[t];
    p = prv[t];
    n = nxt[t];
    if (p == NIL) head[l] = n;
    else nxt[p[5:0]] = n;
    if (n == NIL) tail[l] = p;
    else prv[n[5:0]] = p;
    if (head[l] == NIL) rdy_mask &= ~(32'h8000_0000 >> l);
    prv[t] = NIL;
    nxt[t] = NIL;
    queued[t] = 0;
  endfunction

  function automatic status_t pick_next(bit yld);
    int b;
    if (locks > 0) return ST_LOCKED;
    if (cur_v && cur_run) begin
      if (!yld && int'(lvl[cur]) <= int'(clz(rdy_mask))) return ST_DONE;
      cur_run = 0;
      enqueue(cur);
    end
    hint = 0;
    if (rdy_mask == 0) begin
      cur_v = 0;
      cur = '0;
      return ST_IDLE;
    end
    b = clz(rdy_mask);
    cur = head[b][5:0];
    dequeue(cur);
    cur_v = 1;
    cur_run = 1;
    return ST_SWITCHED;
  endfunction

  function automatic sched_result_t sched_step(cmd_t c, logic [5:0] t, logic [4:0] p);
    status_t st;
    logic running_self;
    sched_result_t r;
    st = ST_DONE;
    running_self = cur_v && cur_run && cur == t;
    case (c)
      CMD_READY: if (!queued[t] && !running_self) begin
        lvl[t] = p;
        enqueue(t);
      end
      CMD_REMOVE: if (queued[t]) dequeue(t);
      CMD_RESCHED: if (hint) st = pick_next(0);
      CMD_YIELD: st = pick_next(1);
      CMD_LOCK: if (locks < 255) locks++;
      CMD_UNLOCK: if (locks > 0) locks--;
      CMD_SET_PRIO: if (lvl[t] != p) begin
        if (queued[t]) begin
          dequeue(t);
          lvl[t] = p;
          enqueue(t);
        end else begin
          lvl[t] = p;
          if (running_self) hint = 1;
        end
        if (hint) st = pick_next(0);
      end
      default: begin
        if (cur_v && cur_run) begin
          cur_run = 0;
          hint = 1;
        end
        if (hint) st = pick_next(0);
      end
    endcase
    r.status = st;
    r.thread = cur;
    r.valid = cur_v;
    r.best = clz(rdy_mask);
    r.levels = rdy_mask;
    return r;
  endfunction

  assign pending = expected_q.size();

  initial sched_reset();

  always @(posedge clk) begin
    sched_result_t e, a;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(sched_step(cmd_t'(s_axis_tuser), s_axis_tdata[5:0],
                                        s_axis_tdata[10:6]));
      if (m_axis_tvalid && m_axis_tready) begin
        a.status = status_t'(m_axis_tuser);
        a.thread = m_axis_tdata[5:0];
        a.valid = m_axis_tdata[6];
        a.best = m_axis_tdata[12:7];
        a.levels = m_axis_tdata[44:13];
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== a || m_axis_tdata[47:45] !== 3'b0) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/priority_ready_queue_scheduler_test.sv
// Top of the scheduler bench: clock, reset, command stimulus and verdict.
module priority_ready_queue_scheduler_test;
  import prqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [2:0]  s_axis_tuser;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [1:0]  m_axis_tuser;
  logic [47:0] m_axis_tdata;
  int          fail_count, pending;
  int          send_idle_pct, recv_idle_pct, idle_cycles;
  bit          hold_off;

  priority_ready_queue_scheduler DUT (.*);
  priority_ready_queue_scheduler_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("** priority_ready_queue_scheduler: FAILED **");
      $finish;
    end
  end

  // tvalid stays high between back-to-back beats; it drops only while idling
  task automatic send_cmd(cmd_t c, int t, int p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {5'b0, 5'(p), 6'(t)};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // mostly ready and scheduling commands over a small thread pool, with occasional locks
  task automatic random_cmds(int n);
    int r, t, p;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      t = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11);
      p = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3);
      if (r < 30) send_cmd(CMD_READY, t, p);
      else if (r < 40) send_cmd(CMD_REMOVE, t, p);
      else if (r < 55) send_cmd(CMD_RESCHED, t, p);
      else if (r < 68) send_cmd(CMD_YIELD, t, p);
      else if (r < 72) send_cmd(CMD_LOCK, t, p);
      else if (r < 77) send_cmd(CMD_UNLOCK, t, p);
      else if (r < 90) send_cmd(CMD_SET_PRIO, t, p);
      else send_cmd(CMD_BLOCK, t, p);
    end
  endtask

  initial begin
    s_axis_tvalid = 0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;
    hold_off = 0;
    idle_cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 85;
    @(posedge clk);
    while (rst) @(posedge clk);
    // directed: empty scheduler, extremes, lock saturation, every command
    send_cmd(CMD_YIELD, 0, 0);
    send_cmd(CMD_RESCHED, 0, 0);
    send_cmd(CMD_READY, 63, 31);
    send_cmd(CMD_READY, 0, 0);
    send_cmd(CMD_READY, 0, 5);
    send_cmd(CMD_RESCHED, 0, 0);
    send_cmd(CMD_READY, 0, 3);
    send_cmd(CMD_READY, 42, 21);
    send_cmd(CMD_REMOVE, 42, 0);
    send_cmd(CMD_REMOVE, 42, 0);
    send_cmd(CMD_SET_PRIO, 63, 0);
    send_cmd(CMD_SET_PRIO, 63, 31);
    send_cmd(CMD_SET_PRIO, 0, 31);
    send_cmd(CMD_LOCK, 0, 0);
    send_cmd(CMD_YIELD, 0, 0);
    send_cmd(CMD_UNLOCK, 0, 0);
    send_cmd(CMD_UNLOCK, 0, 0);
    send_cmd(CMD_BLOCK, 21, 10);
    send_cmd(CMD_BLOCK, 0, 0);
    send_cmd(CMD_YIELD, 0, 0);
    for (int i = 0; i < 257; i++) send_cmd(CMD_LOCK, 0, 0);
    send_cmd(CMD_YIELD, 0, 0);
    for (int i = 0; i < 256; i++) send_cmd(CMD_UNLOCK, 0, 0);
    random_cmds(350);
    send_idle_pct = 85;
    recv_idle_pct = 23;
    random_cmds(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1;
    random_cmds(470);
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** priority_ready_queue_scheduler: PASSED **");
    else
      $display("** priority_ready_queue_scheduler: FAILED **");
    $finish;
  end
endmodule
